[rtl/ftwa_pkg.sv]
// Shared types and codes for the flow table with aging.
`default_nettype none
package ftwa_pkg;

  typedef enum logic [2:0] {
    K_LOOKUP    = 3'd0,
    K_SET_PORT  = 3'd1,
    K_REPLACE   = 3'd2,
    K_DROP_PORT = 3'd3,
    K_DROP_DST  = 3'd4,
    K_DROP_BOTH = 3'd5,
    K_SET_DL    = 3'd6,
    K_CLEAN     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic init_step;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_busy;
  } sts_t;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 8;

endpackage
`default_nettype wire

[rtl/flow_table_with_aging_top.sv]
// Flow table with aging: one full table sweep per operation.
// Each operation is taken in idle and swept slot by slot through the table (one read per slot,
// from the single read address of the table memory), then a drain and a commit step
// register the result beat; no new operation is taken until the block is back in idle.
// A result waiting at the output holds the next operation at commit.
// Reset: synchronous; a clearing pass marks every slot free before the first operation.
`default_nettype none
module flow_table_with_aging_top #(
  parameter int ENTRIES   = 64,
  parameter int PORT_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // src_addr, dst_addr, src_endpoint, dst_endpoint, port, new_port, time_req
  input  wire logic [ftwa_pkg::IN_DATA_W-1:0] s_tdata,
  // kind
  input  wire logic [2:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // found_port
  output logic [ftwa_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status
  output logic [1:0]                          m_tuser
);
  import ftwa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ftwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftwa_datapath #(
    .ENTRIES   (ENTRIES),
    .PORT_BITS (PORT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

[rtl/ftwa_ctrl.sv]
// Sequencer for clearing, table sweep and result commit.
`default_nettype none
module ftwa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire ftwa_pkg::sts_t sts,
  output ftwa_pkg::cmd_t     cmd
);
  import ftwa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (sts.cnt_last) state_next = S_IDLE;
      S_IDLE:   if (s_tvalid) state_next = S_SCAN;
      S_SCAN:   if (sts.cnt_last) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_COMMIT;
      S_COMMIT: if (!sts.out_busy) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_INIT:   cmd.init_step = 1'b1;
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_SCAN:   cmd.scan_step = 1'b1;
      S_DRAIN:  ;
      S_COMMIT: cmd.commit = !sts.out_busy;
      default:  ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.cnt_last) |=> (state == S_DRAIN))
    else $error("sweep did not end in drain");
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == S_IDLE))
    else $error("commit did not return to idle");
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == S_IDLE))
    else $error("ready outside idle");

endmodule
`default_nettype wire

[rtl/ftwa_datapath.sv]
// Flow table memory, sweep counter, per-entry update logic and result register.
`default_nettype none
module ftwa_datapath #(
  parameter int ENTRIES   = 64,
  parameter int PORT_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ftwa_pkg::cmd_t                cmd,
  output ftwa_pkg::sts_t                     sts,
  input  wire logic [ftwa_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [2:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ftwa_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [1:0]                         m_tuser
);
  import ftwa_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  // table memory
  logic                 mem_used [ENTRIES];
  logic [63:0]          mem_key  [ENTRIES];
  logic [PORT_BITS-1:0] mem_port [ENTRIES];
  logic                 mem_hd   [ENTRIES];
  logic [31:0]          mem_dl   [ENTRIES];

  logic                 rd_used, rd_hd;
  logic [63:0]          rd_key;
  logic [PORT_BITS-1:0] rd_port;
  logic [31:0]          rd_dl;

  logic                 we;
  logic [IW-1:0]        waddr;
  logic                 w_used, w_hd;
  logic [63:0]          w_key;
  logic [PORT_BITS-1:0] w_port;
  logic [31:0]          w_dl;

  logic [IW-1:0] cnt, pidx;
  logic          pvalid;

  // latched item
  kind_t                kind;
  logic [63:0]          key;
  logic [PORT_BITS-1:0] port_n, newp_n;
  logic [31:0]          t;
  logic [15:0]          port16, newp16;

  // sweep results
  logic                 match_hit, free_hit;
  logic [IW-1:0]        midx, fidx;
  logic [PORT_BITS-1:0] m_port;
  logic                 m_hd;
  logic [31:0]          m_dl;

  logic                 hit_now;
  logic [15:0]          found16;

  assign port16 = {8'b0, s_tdata[71:64]};
  assign newp16 = {8'b0, s_tdata[79:72]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem_used[waddr] <= w_used;
      mem_key[waddr]  <= w_key;
      mem_port[waddr] <= w_port;
      mem_hd[waddr]   <= w_hd;
      mem_dl[waddr]   <= w_dl;
    end
  end

  always_ff @(posedge clk) begin
    rd_used <= mem_used[cnt];
    rd_key  <= mem_key[cnt];
    rd_port <= mem_port[cnt];
    rd_hd   <= mem_hd[cnt];
    rd_dl   <= mem_dl[cnt];
  end

  assign sts.cnt_last = (cnt == LAST);
  assign sts.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      pvalid <= 1'b0;
    end else begin
      pvalid <= cmd.scan_step;
      if (cmd.load) cnt <= '0;
      else if (cmd.init_step || cmd.scan_step) cnt <= sts.cnt_last ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pidx <= cnt;
    if (cmd.load) begin
      kind   <= kind_t'(s_tuser);
      key    <= {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]};
      port_n <= port16[PORT_BITS-1:0];
      newp_n <= newp16[PORT_BITS-1:0];
      t      <= s_tdata[111:80];
    end
  end

  assign hit_now = rd_used && (rd_key == key);

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
    end else if (pvalid) begin
      if (hit_now && !match_hit) begin
        match_hit <= 1'b1;
        midx      <= pidx;
        m_port    <= rd_port;
        m_hd      <= rd_hd;
        m_dl      <= rd_dl;
      end
      if (!rd_used && !free_hit) begin
        free_hit <= 1'b1;
        fidx     <= pidx;
      end
    end
  end

  always_comb begin
    we     = 1'b0;
    waddr  = pidx;
    w_used = rd_used;
    w_key  = rd_key;
    w_port = rd_port;
    w_hd   = rd_hd;
    w_dl   = rd_dl;
    if (cmd.init_step) begin
      we     = 1'b1;
      waddr  = cnt;
      w_used = 1'b0;
    end else if (pvalid) begin
      case (kind) inside
        K_REPLACE: if (rd_used && rd_port == port_n) begin
          we     = 1'b1;
          w_port = newp_n;
        end
        K_DROP_PORT, K_DROP_DST, K_DROP_BOTH: begin
          if (rd_used &&
              ((kind == K_DROP_PORT && rd_port == port_n) ||
               (kind == K_DROP_DST && rd_key[47:32] == key[47:32]) ||
               (kind == K_DROP_BOTH && rd_port == port_n &&
                rd_key[47:32] == key[47:32]))) begin
            we = 1'b1;
            // an armed deadline keeps the slot alive with no port
            if (rd_hd) w_port = '0;
            else       w_used = 1'b0;
          end
        end
        K_CLEAN: if (rd_used && ((rd_hd && rd_dl <= t) || (!rd_hd && rd_port == '0))) begin
          we     = 1'b1;
          w_used = 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.commit && (kind == K_SET_PORT || kind == K_SET_DL)
                 && (match_hit || free_hit)) begin
      we     = 1'b1;
      waddr  = match_hit ? midx : fidx;
      w_used = 1'b1;
      w_key  = key;
      w_port = match_hit ? m_port : '0;
      w_hd   = match_hit ? m_hd : 1'b0;
      w_dl   = match_hit ? m_dl : '0;
      if (kind == K_SET_PORT) w_port = port_n;
      else begin
        w_hd = 1'b1;
        w_dl = t;
      end
    end
  end

  assign found16 = 16'(m_port);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.commit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= '0;
      m_tuser <= ST_OK;
      case (kind) inside
        K_LOOKUP: begin
          if (match_hit) m_tdata <= found16[7:0];
          else           m_tuser <= ST_MISS;
        end
        K_SET_PORT, K_SET_DL: if (!match_hit && !free_hit) m_tuser <= ST_FULL;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("result overwritten while waiting");
  assert property (@(posedge clk) disable iff (rst)
    (pvalid && cmd.scan_step) |-> (pidx != cnt))
    else $error("write-back collides with read address");
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (!match_hit && !free_hit && cnt == '0))
    else $error("sweep state not cleared on load");

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the flow table with aging: random and directed operations against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import ftwa_pkg::*;

  localparam int ENTRIES  = 64;
  localparam int WDOG_MAX = 20000;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [15:0] src_ep;
    logic [15:0] dst_ep;
    logic [7:0]  port;
    logic [7:0]  new_port;
    logic [31:0] time_req;
  } op_t;

  typedef struct packed {
    logic [7:0] found_port;
    status_t    status;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  always #4 clk = ~clk;

  flow_table_with_aging_top #(.ENTRIES(ENTRIES), .PORT_BITS(8)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // predictor copy of the table
  logic        fl_used [ENTRIES];
  logic [63:0] fl_key  [ENTRIES];
  logic [7:0]  fl_port [ENTRIES];
  logic        fl_has_dl [ENTRIES];
  logic [31:0] fl_dl   [ENTRIES];

  op_t    pending_ops[$];
  reply_t expected_replies[$];
  int     n_errors = 0;
  bit     stim_done = 0;
  bit     hold_send = 0;
  bit     calm = 0;
  int     wdog = 0;
  bit     in_acc = 0;

  // keys from a small pool so hits and a full table are both common
  logic [63:0] key_pool[96];

  function automatic reply_t apply_op(op_t o);
    reply_t r;
    logic [63:0] key;
    int s;
    bit pm, dm;
    r.found_port = '0;
    r.status = ST_OK;
    key = {o.src_addr, o.dst_addr, o.src_ep, o.dst_ep};
    s = -1;
    if (o.kind == K_LOOKUP || o.kind == K_SET_PORT || o.kind == K_SET_DL)
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (fl_used[i] && fl_key[i] == key) s = i;
    case (o.kind)
      K_LOOKUP: begin
        if (s < 0) r.status = ST_MISS;
        else r.found_port = fl_port[s];
      end
      K_SET_PORT, K_SET_DL: begin
        if (s < 0) begin
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!fl_used[i]) s = i;
          if (s >= 0) begin
            fl_used[s] = 1'b1;
            fl_key[s] = key;
            fl_port[s] = '0;
            fl_has_dl[s] = 1'b0;
            fl_dl[s] = '0;
          end
        end
        if (s < 0) r.status = ST_FULL;
        else if (o.kind == K_SET_PORT) fl_port[s] = o.port;
        else begin
          fl_has_dl[s] = 1'b1;
          fl_dl[s] = o.time_req;
        end
      end
      K_REPLACE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (fl_used[i] && fl_port[i] == o.port) fl_port[i] = o.new_port;
      end
      K_DROP_PORT, K_DROP_DST, K_DROP_BOTH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          pm = fl_port[i] == o.port;
          dm = fl_key[i][47:32] == o.dst_addr;
          if (fl_used[i] && ((o.kind == K_DROP_PORT && pm) || (o.kind == K_DROP_DST && dm) ||
              (o.kind == K_DROP_BOTH && pm && dm))) begin
            // armed timer keeps the flow alive
            if (fl_has_dl[i]) fl_port[i] = '0;
            else fl_used[i] = 1'b0;
          end
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (fl_used[i] && ((fl_has_dl[i] && fl_dl[i] <= o.time_req) ||
              (!fl_has_dl[i] && fl_port[i] == '0)))
            fl_used[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic op_t make_op(kind_t k, logic [63:0] key, logic [7:0] p,
                                  logic [7:0] np, logic [31:0] t);
    op_t o;
    o.kind = k;
    {o.src_addr, o.dst_addr, o.src_ep, o.dst_ep} = key;
    o.port = p;
    o.new_port = np;
    o.time_req = t;
    return o;
  endfunction

  function automatic op_t rand_op();
    logic [63:0] key;
    logic [7:0] p;
    logic [31:0] t;
    kind_t k;
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) k = K_SET_PORT;
    else if (sel < 45) k = K_LOOKUP;
    else if (sel < 60) k = K_SET_DL;
    else if (sel < 66) k = K_CLEAN;
    else k = kind_t'($urandom_range(7));
    key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(95)];
    p = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4));
    t = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(2000));
    return make_op(k, key, p, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4)), t);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    n_errors++;
  endtask

  // input acceptance is taken at the rising edge and acted on by the driver
  // at the following falling edge
  always @(posedge clk) begin
    in_acc <= !rst && s_tvalid && s_tready;
  end

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) begin
        expected_replies.push_back(apply_op(pending_ops.pop_front()));
      end
      if (s_tvalid && !in_acc) begin
        // hold the beat
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0 && !hold_send) begin
        if (!calm && $urandom_range(9) == 0) begin
          send_gap = $urandom_range(1, 9);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= {pending_ops[0].time_req, pending_ops[0].new_port, pending_ops[0].port,
                      pending_ops[0].dst_ep, pending_ops[0].src_ep, pending_ops[0].dst_addr,
                      pending_ops[0].src_addr};
          s_tuser <= pending_ops[0].kind;
        end
      end else s_tvalid <= 1'b0;
    end
  end

  // receive side back-pressure
  int stall = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(7) == 0) begin
        stall = $urandom_range(1, 9);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // monitor
  reply_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (m_tvalid && m_tready) begin
        // the driver pushes the expectation at the next falling edge; a result
        // in the same cycle as its input beat cannot happen, as the table sweep lies between
        if (expected_replies.size() == 0) begin
          $display("result beat with nothing expected");
          n_errors++;
        end else begin
          want = expected_replies.pop_front();
          if (m_tdata !== want.found_port)
            report_mismatch("found_port", m_tdata, want.found_port);
          if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_tvalid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [63:0] k0;
    for (int i = 0; i < 96; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 0; i < ENTRIES; i++) begin
      fl_used[i] = 1'b0; fl_key[i] = '0; fl_port[i] = '0; fl_has_dl[i] = 1'b0; fl_dl[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    k0 = key_pool[2];
    // directed
    pending_ops.push_back(make_op(K_LOOKUP, k0, 0, 0, 0));
    pending_ops.push_back(make_op(K_SET_PORT, key_pool[0], 8'hff, 0, 0));
    pending_ops.push_back(make_op(K_SET_PORT, key_pool[1], 8'h00, 0, 0));
    pending_ops.push_back(make_op(K_LOOKUP, key_pool[1], 0, 0, 0));
    pending_ops.push_back(make_op(K_LOOKUP, key_pool[0], 0, 0, 0));
    pending_ops.push_back(make_op(K_SET_DL, k0, 0, 0, 32'hffff_ffff));
    pending_ops.push_back(make_op(K_REPLACE, '0, 8'h00, 8'h07, 0));
    pending_ops.push_back(make_op(K_LOOKUP, k0, 0, 0, 0));
    pending_ops.push_back(make_op(K_DROP_PORT, '0, 8'h07, 0, 0));
    pending_ops.push_back(make_op(K_LOOKUP, k0, 0, 0, 0));
    pending_ops.push_back(make_op(K_SET_PORT, k0, 8'h05, 0, 0));
    pending_ops.push_back(make_op(K_DROP_DST, k0, 0, 0, 0));
    pending_ops.push_back(make_op(K_SET_PORT, key_pool[3], 8'h09, 0, 0));
    pending_ops.push_back(make_op(K_DROP_BOTH, key_pool[3], 8'h09, 0, 0));
    pending_ops.push_back(make_op(K_SET_DL, k0, 0, 0, 32'd100));
    pending_ops.push_back(make_op(K_CLEAN, '0, 0, 0, 32'd99));
    pending_ops.push_back(make_op(K_LOOKUP, k0, 0, 0, 0));
    pending_ops.push_back(make_op(K_CLEAN, '0, 0, 0, 32'd100));
    pending_ops.push_back(make_op(K_LOOKUP, k0, 0, 0, 0));
    pending_ops.push_back(make_op(K_CLEAN, '0, 0, 0, 32'hffff_ffff));
    wait_drained();
    // fill the table past capacity
    for (int i = 0; i < ENTRIES + 2; i++)
      pending_ops.push_back(make_op(K_SET_PORT, {$urandom, $urandom}, 8'($urandom), 0, 0));
    wait_drained();
    pending_ops.push_back(make_op(K_SET_DL, {$urandom, $urandom}, 0, 0, 5));
    pending_ops.push_back(make_op(K_CLEAN, '0, 0, 0, 32'hffff_ffff));
    for (int i = 0; i < 800; i++) begin
      pending_ops.push_back(rand_op());
      if (i == 400) begin
        wait_drained();
        hold_send = 1;
        repeat (20) @(posedge clk);
        hold_send = 0;
      end
      if (i == 700) calm = 1;
      while (pending_ops.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (ENTRIES + 10) @(posedge clk);
    if (n_errors == 0 && expected_replies.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
`default_nettype wire

[flow_table_with_aging_top.f]
rtl/ftwa_pkg.sv
rtl/ftwa_ctrl.sv
rtl/ftwa_datapath.sv
rtl/flow_table_with_aging_top.sv
sim/tb.sv
